// ===== rtl/pose_layer_rotation_blend_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rotation blend unit
// Clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POSE_LAYER_ROTATION_BLEND_UNIT_ASSERT_SVH
`define POSE_LAYER_ROTATION_BLEND_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("plrb assertion failed");
`define PLRB_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("plrb assertion failed");
`else
`define PLRB_ASSERT(lbl, prop)
`define PLRB_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// ===== rtl/plrb_pkg.sv =====
// ---------------------------------------------------------------------------
// plrb_pkg
// Widths, sideband types and rounding helpers of the rotation blend unit.
// ---------------------------------------------------------------------------
`default_nettype none
package plrb_pkg;

    localparam int COMP_BITS = 16;
    localparam int FP_W      = COMP_BITS + 1;   // component with room for +1.0
    localparam int Q_W       = 34;              // signed Q30 working value
    localparam int MAG_W     = 32;
    localparam int SS_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int RND_W     = 50;
    localparam int RES_W     = 35;

    localparam logic [15:0] W_ONE = 16'd32768;
    localparam logic signed [Q_W-1:0] Q30_ONE = 34'sd1073741824;
    localparam logic signed [FP_W-1:0] FP_ONE = 17'sd32768;

    typedef logic signed [Q_W-1:0] t_q30;

    typedef struct packed {
        logic [3:0][FP_W-1:0] fp;
        logic [15:0]          w;
        logic                 add;
        logic                 wz;
    } t_side1;

    typedef struct packed {
        logic [3:0][FP_W-1:0] fp;
        logic                 wz;
    } t_side2;

    // shift right by 15, half away from zero
    function automatic logic signed [RES_W-1:0] round15(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] m;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        m   = (mag + RND_W'(16384)) >> 15;
        round15 = v[RND_W-1] ? -$signed(m[RES_W-1:0]) : $signed(m[RES_W-1:0]);
    endfunction

    function automatic logic [COMP_BITS-1:0] sat16(input logic signed [RES_W-1:0] v);
        if (v > $signed(RES_W'(32767))) begin
            sat16 = 16'h7fff;
        end else if (v < -$signed(RES_W'(32768))) begin
            sat16 = 16'h8000;
        end else begin
            sat16 = v[COMP_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pose_layer_rotation_blend_unit.sv =====
// ---------------------------------------------------------------------------
// pose_layer_rotation_blend_unit
// Blends one bone rotation of one layer: nlerp of the authored quaternion
// from identity by intensity, optional additive pre-multiply by the current
// rotation, nlerp from the current rotation by weight, unit result (a zero weight passes the current rotation through).
//
// channel   dir  tdata                          tuser
// s_axis    in   from_x..w, auth_x..w, weight,  from_present, additive
//                intensity (16 bits each)
// m_axis    out  res_x..res_w (16 bits each)    -
//
// One request per cycle while o_s_axis_tready is high. Each of the two
// normalizers holds 32 square-root and 32 divider stages. Reset clears only
// valid bits and the output queue count.
// A stalled output fills the two-entry queue, then the whole pipeline
// holds and o_s_axis_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none
module pose_layer_rotation_blend_unit
    import plrb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // from_x, from_y, from_z, from_w, auth_x, auth_y, auth_z, auth_w,
    // weight, intensity
    input  logic [159:0] i_s_axis_tdata,
    // from_present, additive
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // res_x, res_y, res_z, res_w
    output logic [63:0]  o_m_axis_tdata
);

    localparam int S1_W = $bits(t_side1);
    localparam int S2_W = $bits(t_side2);

    logic en;

    // stage 1: capture
    logic                 r1_v;
    logic signed [FP_W-1:0] r1_fp [4];
    logic signed [15:0]   r1_a  [4];
    logic [15:0]          r1_w, r1_k;
    logic                 r1_add, r1_wz;

    // stage 2: lerp of authored from identity
    logic   r2_v;
    t_side1 r2_side;
    t_q30   r2_r [4];

    logic   n1_v;
    t_side1 n1_side;
    t_q30   n1_q [4];

    logic                   r3_v;
    t_side1                 r3_side;
    t_q30                   r3_t  [4];
    logic signed [50:0]     r3_pq [4][4];

    logic                   r4_v;
    t_side1                 r4_side;
    t_q30                   r4_t [4];

    logic                   r5_v;
    t_side1                 r5_side;
    logic signed [50:0]     r5_pd [4];
    logic signed [33:0]     r5_fw [4];
    logic signed [50:0]     r5_tw [4];

    logic                   r6_v;
    t_side2                 r6_side;
    logic                   r6_s;
    logic signed [33:0]     r6_fw [4];
    logic signed [50:0]     r6_tw [4];

    logic                   r7_v;
    t_side2                 r7_side;
    t_q30                   r7_r [4];

    logic                   n2_v;
    t_side2                 n2_side;
    t_q30                   n2_q [4];

    logic [63:0]            out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= n1_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] w_raw, k_raw;
        logic signed [15:0] f;
        logic signed [33:0] kp;
        logic signed [52:0] qm [4];
        logic signed [52:0] dot;
        logic signed [RND_W-1:0] x;
        if (en) begin
            // stage 1
            w_raw = i_s_axis_tdata[143:128];
            k_raw = i_s_axis_tdata[159:144];
            r1_w   <= (w_raw > W_ONE) ? W_ONE : w_raw;
            r1_k   <= (k_raw > W_ONE) ? W_ONE : k_raw;
            r1_wz  <= (w_raw == 16'd0);
            r1_add <= i_s_axis_tuser[1];
            for (int i = 0; i < 4; i++) begin
                f = $signed(i_s_axis_tdata[16*i +: 16]);
                if (i_s_axis_tuser[0]) begin
                    r1_fp[i] <= FP_W'(f);
                end else begin
                    r1_fp[i] <= (i == 3) ? FP_ONE : '0;
                end
                r1_a[i] <= $signed(i_s_axis_tdata[64+16*i +: 16]);
            end

            // stage 2
            for (int i = 0; i < 4; i++) begin
                kp = 34'($signed({r1_a[i][15], r1_a[i]}) * $signed({1'b0, r1_k}));
                if (r1_a[3][15]) begin
                    kp = -kp;
                end
                if (i == 3) begin
                    r2_r[i] <= $signed({3'b000, 16'(W_ONE - r1_k), 15'b0}) + kp;
                end else begin
                    r2_r[i] <= kp;
                end
                r2_side.fp[i] <= r1_fp[i];
            end
            r2_side.w   <= r1_w;
            r2_side.add <= r1_add;
            r2_side.wz  <= r1_wz;

            // stage 3: partial products of the quaternion product
            r3_side <= n1_side;
            r3_t    <= n1_q;
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    r3_pq[j][i] <= 51'($signed(n1_side.fp[j]) * n1_q[i]);
                end
            end

            // stage 4: current * target, or target as is
            qm[0] = 53'(r3_pq[3][0]) + 53'(r3_pq[0][3]) + 53'(r3_pq[1][2]) - 53'(r3_pq[2][1]);
            qm[1] = 53'(r3_pq[3][1]) - 53'(r3_pq[0][2]) + 53'(r3_pq[1][3]) + 53'(r3_pq[2][0]);
            qm[2] = 53'(r3_pq[3][2]) + 53'(r3_pq[0][1]) - 53'(r3_pq[1][0]) + 53'(r3_pq[2][3]);
            qm[3] = 53'(r3_pq[3][3]) - 53'(r3_pq[0][0]) - 53'(r3_pq[1][1]) - 53'(r3_pq[2][2]);
            r4_side <= r3_side;
            for (int i = 0; i < 4; i++) begin
                r4_t[i] <= r3_side.add ? Q_W'(round15(RND_W'(qm[i]))) : r3_t[i];
            end

            // stage 5: products of the weight lerp
            r5_side <= r4_side;
            for (int i = 0; i < 4; i++) begin
                r5_pd[i] <= 51'($signed(r4_side.fp[i]) * r4_t[i]);
                r5_fw[i] <= 34'($signed(r4_side.fp[i])
                               * $signed({1'b0, 16'(W_ONE - r4_side.w)}));
                r5_tw[i] <= 51'(r4_t[i] * $signed({1'b0, r4_side.w}));
            end

            // stage 6: hemisphere sign
            dot = 53'(r5_pd[0]) + 53'(r5_pd[1]) + 53'(r5_pd[2]) + 53'(r5_pd[3]);
            r6_s       <= dot[52];
            r6_side.fp <= r5_side.fp;
            r6_side.wz <= r5_side.wz;
            r6_fw      <= r5_fw;
            r6_tw      <= r5_tw;

            // stage 7: lerp terms
            r7_side <= r6_side;
            for (int i = 0; i < 4; i++) begin
                x = (RND_W'(r6_fw[i]) <<< 15)
                    + (r6_s ? -RND_W'(r6_tw[i]) : RND_W'(r6_tw[i]));
                r7_r[i] <= Q_W'(round15(x));
            end
        end
    end

    plrb_norm #(.SIDE_W(S1_W)) u_norm_int (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_side  (r2_side),
        .i_r     (r2_r),
        .o_valid (n1_v),
        .o_side  (n1_side),
        .o_q     (n1_q)
    );

    plrb_norm #(.SIDE_W(S2_W)) u_norm_wgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_side  (r7_side),
        .i_r     (r7_r),
        .o_valid (n2_v),
        .o_side  (n2_side),
        .o_q     (n2_q)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (n2_side.wz) begin
                out_data[16*i +: 16] = sat16(RES_W'($signed(n2_side.fp[i])));
            end else begin
                out_data[16*i +: 16] = sat16(round15(RND_W'(n2_q[i])));
            end
        end
    end

    plrb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n2_v && en),
        .i_data  (out_data),
        .o_room  (en),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = en;

endmodule
`default_nettype wire

// ===== rtl/plrb_isqrt.sv =====
// ---------------------------------------------------------------------------
// plrb_isqrt
// Pipelined integer square root, two radicand bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module plrb_isqrt
    import plrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SS_W-1:0]   i_x,
    output logic [ROOT_W-1:0] o_root
);

    logic [33:0]       r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];
    logic [SS_W-1:0]   r_x    [SQ_STEPS];

    logic [33:0]       s_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] s_root [SQ_STEPS];
    logic [SS_W-1:0]   s_x    [SQ_STEPS];
    logic [33:0]       n_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] n_root [SQ_STEPS];

    always_comb begin
        logic [35:0] sh;
        logic [35:0] tr;
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_x[0]    = i_x;
        for (int k = 1; k < SQ_STEPS; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_x[k]    = r_x[k-1];
        end
        for (int k = 0; k < SQ_STEPS; k++) begin
            sh = {s_rem[k], s_x[k][2*(SQ_STEPS-1-k) +: 2]};
            tr = {2'b00, s_root[k], 2'b01};
            if (sh >= tr) begin
                n_rem[k]  = 34'(sh - tr);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh[33:0];
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= s_x[k];
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/plrb_div.sv =====
// ---------------------------------------------------------------------------
// plrb_div
// Pipelined restoring divider: round(mag * 2^30 / den), one quotient bit
// per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module plrb_div
    import plrb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MAG_W-1:0]     i_mag,
    input  logic [ROOT_W-1:0]    i_den,
    output logic [DIV_STEPS-1:0] o_quo
);

    logic [62:0]          dd;
    logic [MAG_W-1:0]     r0_rem;
    logic [DIV_STEPS-1:0] r0_low;
    logic [ROOT_W-1:0]    r0_den;

    logic [MAG_W-1:0]     r_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS];
    logic [ROOT_W-1:0]    r_den [DIV_STEPS];

    logic [MAG_W-1:0]     s_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_low [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_q   [DIV_STEPS];
    logic [ROOT_W-1:0]    s_den [DIV_STEPS];
    logic [MAG_W-1:0]     n_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_q   [DIV_STEPS];

    // dividend with half the divisor added for rounding
    assign dd = {1'b0, i_mag, 30'b0} + {32'b0, i_den[ROOT_W-1:1]};

    always_comb begin
        logic [MAG_W:0] sh;
        s_rem[0] = r0_rem;
        s_low[0] = r0_low;
        s_q[0]   = '0;
        s_den[0] = r0_den;
        for (int k = 1; k < DIV_STEPS; k++) begin
            s_rem[k] = r_rem[k-1];
            s_low[k] = r_low[k-1];
            s_q[k]   = r_q[k-1];
            s_den[k] = r_den[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh = {s_rem[k], s_low[k][DIV_STEPS-1-k]};
            if (sh >= {1'b0, s_den[k]}) begin
                n_rem[k] = MAG_W'(sh - {1'b0, s_den[k]});
                n_q[k]   = {s_q[k][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[MAG_W-1:0];
                n_q[k]   = {s_q[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_rem <= dd[62:31];
            r0_low <= dd[30:0];
            r0_den <= i_den;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= s_low[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/plrb_norm.sv =====
// ---------------------------------------------------------------------------
// plrb_norm
// Quaternion normalizer: squares, sum, square root, four dividers; a zero
// length gives identity. Sideband data travels alongside.
// ---------------------------------------------------------------------------
`default_nettype none
module plrb_norm
    import plrb_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SIDE_W-1:0] i_side,
    input  t_q30              i_r [4],
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_side,
    output t_q30              o_q [4]
);

    logic              r1_v, r2_v, r3_v;
    logic [SIDE_W-1:0] r1_side, r2_side, r3_side;
    logic [3:0]        r1_neg, r2_neg, r3_neg;
    logic [MAG_W-1:0]  r1_mag [4];
    logic [MAG_W-1:0]  r2_mag [4];
    logic [MAG_W-1:0]  r3_mag [4];
    logic [SS_W-1:0]   r2_sq  [4];
    logic [SS_W-1:0]   r3_ss;

    logic              ra_v    [SQ_STEPS];
    logic [SIDE_W-1:0] ra_side [SQ_STEPS];
    logic [3:0]        ra_neg  [SQ_STEPS];
    logic [MAG_W-1:0]  ra_mag  [SQ_STEPS][4];

    logic              rb_v    [DIV_LAT];
    logic [SIDE_W-1:0] rb_side [DIV_LAT];
    logic [3:0]        rb_neg  [DIV_LAT];
    logic              rb_nz   [DIV_LAT];

    logic                 r_v_o;
    logic [SIDE_W-1:0]    r_side_o;
    t_q30                 r_q_o [4];
    logic [ROOT_W-1:0]    w_root;
    logic [DIV_STEPS-1:0] w_quo [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_v_o <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                ra_v[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                rb_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            ra_v[0] <= r3_v;
            for (int k = 1; k < SQ_STEPS; k++) begin
                ra_v[k] <= ra_v[k-1];
            end
            rb_v[0] <= ra_v[SQ_STEPS-1];
            for (int k = 1; k < DIV_LAT; k++) begin
                rb_v[k] <= rb_v[k-1];
            end
            r_v_o <= rb_v[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            r2_neg  <= r1_neg;
            r3_neg  <= r2_neg;
            r3_ss   <= r2_sq[0] + r2_sq[1] + r2_sq[2] + r2_sq[3];
            for (int i = 0; i < 4; i++) begin
                r1_neg[i] <= i_r[i][Q_W-1];
                r1_mag[i] <= MAG_W'(i_r[i][Q_W-1] ? -i_r[i] : i_r[i]);
                r2_sq[i]  <= SS_W'(r1_mag[i] * r1_mag[i]);
                r2_mag[i] <= r1_mag[i];
                r3_mag[i] <= r2_mag[i];
            end
            ra_side[0] <= r3_side;
            ra_neg[0]  <= r3_neg;
            ra_mag[0]  <= r3_mag;
            for (int k = 1; k < SQ_STEPS; k++) begin
                ra_side[k] <= ra_side[k-1];
                ra_neg[k]  <= ra_neg[k-1];
                ra_mag[k]  <= ra_mag[k-1];
            end
            rb_side[0] <= ra_side[SQ_STEPS-1];
            rb_neg[0]  <= ra_neg[SQ_STEPS-1];
            rb_nz[0]   <= (w_root == '0);
            for (int k = 1; k < DIV_LAT; k++) begin
                rb_side[k] <= rb_side[k-1];
                rb_neg[k]  <= rb_neg[k-1];
                rb_nz[k]   <= rb_nz[k-1];
            end
            r_side_o <= rb_side[DIV_LAT-1];
            for (int i = 0; i < 4; i++) begin
                if (rb_nz[DIV_LAT-1]) begin
                    r_q_o[i] <= (i == 3) ? Q30_ONE : '0;
                end else if (rb_neg[DIV_LAT-1][i]) begin
                    r_q_o[i] <= -$signed({3'b000, w_quo[i]});
                end else begin
                    r_q_o[i] <= $signed({3'b000, w_quo[i]});
                end
            end
        end
    end

    plrb_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r3_ss),
        .o_root (w_root)
    );

    for (genvar i = 0; i < 4; i++) begin : g_lane
        plrb_div u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_mag (ra_mag[SQ_STEPS-1][i]),
            .i_den (w_root),
            .o_quo (w_quo[i])
        );
    end

    assign o_valid = r_v_o;
    assign o_side  = r_side_o;
    assign o_q     = r_q_o;

endmodule
`default_nettype wire

// ===== rtl/plrb_outq.sv =====
// ---------------------------------------------------------------------------
// plrb_outq
// Two-entry output queue; its fill state gates the whole pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pose_layer_rotation_blend_unit_assert.svh"
module plrb_outq
    import plrb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [4*COMP_BITS-1:0] i_data,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [4*COMP_BITS-1:0] o_data
);

    logic [1:0]             r_cnt;
    logic [4*COMP_BITS-1:0] r_head;
    logic [4*COMP_BITS-1:0] r_tail;
    logic                   pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_head <= i_data;
        end else if (pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end
        if (i_push && r_cnt == 2'd1 && !pop) begin
            r_tail <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign o_data  = r_head;

    `PLRB_ASSERT(a_no_push_full, (r_cnt == 2'd2) |-> !i_push)
    `PLRB_ASSERT(a_cnt_range, r_cnt != 2'd3)
    `PLRB_ASSERT_NEXT(a_pass_through, r_cnt == 2'd1 && i_push && pop, r_cnt == 2'd1)

endmodule
`default_nettype wire

// ===== test/plrb_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// plrb_checker
// Watches both stream channels of the rotation blend unit, computes the
// expected blended quaternion for every accepted request and compares it
// component by component with the results in arrival order.
// ---------------------------------------------------------------------------
module plrb_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [159:0] i_s_axis_tdata,
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [63:0]  i_m_axis_tdata,
    output int           o_errors,
    output int           o_pending
);
    localparam longint Q1 = 64'sd1 << 30;

    typedef longint t_quat [4];

    logic [63:0] blend_q[$];

    assign o_pending = blend_q.size();

    function automatic longint rnd_shift(input longint v, input int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic t_quat unit_quat(input t_quat r);
        t_quat o;
        longint unsigned ss;
        longint unsigned n;
        longint unsigned m;
        ss = 0;
        for (int i = 0; i < 4; i++) ss += longint'(r[i] * r[i]);
        n = int_sqrt(ss);
        if (n == 0) begin
            o = '{0, 0, 0, Q1};
            return o;
        end
        for (int i = 0; i < 4; i++) begin
            m = (r[i] < 0) ? -r[i] : r[i];
            m = ((m << 30) + n / 2) / n;
            o[i] = (r[i] < 0) ? -longint'(m) : longint'(m);
        end
        return o;
    endfunction

    function automatic t_quat quat_nlerp(input t_quat a, input t_quat b, input longint t);
        t_quat r;
        longint dot;
        longint s;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        s = (dot < 0) ? -1 : 1;
        for (int i = 0; i < 4; i++) r[i] = rnd_shift(a[i] * (Q1 - t) + s * b[i] * t, 30);
        return unit_quat(r);
    endfunction

    function automatic t_quat quat_mul(input t_quat l, input t_quat r);
        t_quat o;
        o[0] = rnd_shift(l[3]*r[0] + l[0]*r[3] + l[1]*r[2] - l[2]*r[1], 30);
        o[1] = rnd_shift(l[3]*r[1] - l[0]*r[2] + l[1]*r[3] + l[2]*r[0], 30);
        o[2] = rnd_shift(l[3]*r[2] + l[0]*r[1] - l[1]*r[0] + l[2]*r[3], 30);
        o[3] = rnd_shift(l[3]*r[3] - l[0]*r[0] - l[1]*r[1] - l[2]*r[2], 30);
        return o;
    endfunction

    function automatic logic [15:0] to_comp(input longint v);
        longint r;
        r = rnd_shift(v, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [63:0] blend_rotation(input logic [159:0] d, input logic [1:0] u);
        t_quat from_q;
        t_quat auth_q;
        t_quat ident;
        t_quat tgt;
        t_quat res;
        longint w;
        longint k;
        logic [63:0] o;
        w = d[143:128];
        k = d[159:144];
        if (w > 32768) w = 32768;
        if (k > 32768) k = 32768;
        if (w == 0) begin
            return u[0] ? d[63:0] : {16'h7fff, 48'h0};
        end
        ident = '{0, 0, 0, Q1};
        for (int i = 0; i < 4; i++) begin
            from_q[i] = u[0] ? (longint'($signed(d[16*i +: 16])) <<< 15) : ident[i];
            auth_q[i] = longint'($signed(d[64 + 16*i +: 16])) <<< 15;
        end
        tgt = quat_nlerp(ident, auth_q, k << 15);
        if (u[1]) tgt = quat_mul(from_q, tgt);
        res = quat_nlerp(from_q, tgt, w << 15);
        for (int i = 0; i < 4; i++) o[16*i +: 16] = to_comp(res[i]);
        return o;
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        logic [63:0] exp_q;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                blend_q.push_back(blend_rotation(i_s_axis_tdata, i_s_axis_tuser));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (blend_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %h", i_m_axis_tdata);
                end else begin
                    exp_q = blend_q.pop_front();
                    if (exp_q !== i_m_axis_tdata) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10) begin
                            for (int i = 0; i < 4; i++) begin
                                if (exp_q[16*i +: 16] !== i_m_axis_tdata[16*i +: 16]) begin
                                    $display("res comp %0d: exp %h got %h", i,
                                             exp_q[16*i +: 16], i_m_axis_tdata[16*i +: 16]);
                                end
                            end
                        end
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_pose_layer_rotation_blend_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pose_layer_rotation_blend_unit
// Directed corner requests followed by random blends, with random idle
// cycles on the request and result sides; verdict from the checker.
// ---------------------------------------------------------------------------
module tb_pose_layer_rotation_blend_unit;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;   // from_x..w, auth_x..w, weight, intensity
    logic [1:0]   s_tuser;   // from_present, additive
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // res_x..res_w
    int           errors;
    int           pending;
    bit           calm;

    pose_layer_rotation_blend_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    plrb_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(negedge i_clk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    // tvalid stays high after an accepted request; the caller, or the next
    // call when it inserts idle cycles, drops it
    task automatic send_request(input logic [159:0] d, input logic [1:0] u);
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= u;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_blend(input logic [63:0] from_q, input logic [63:0] auth_q,
                              input logic [15:0] w, input logic [15:0] k,
                              input logic present, input logic add);
        send_request({k, w, auth_q, from_q}, {add, present});
    endtask

    localparam logic [63:0] IDENT = {16'h7fff, 48'h0};

    initial begin
        logic [63:0] a;
        logic [63:0] b;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        i_rst_n  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        a = {16'h5a82, 16'h0000, 16'h5a82, 16'h0000};
        b = {16'h6ed9, 16'h0000, 16'h0000, 16'h4000};
        send_blend(a, b, 16'd0, 16'd32768, 1'b1, 1'b0);
        send_blend(a, b, 16'd0, 16'd100, 1'b0, 1'b1);
        send_blend(a, b, 16'd32768, 16'd32768, 1'b1, 1'b0);
        send_blend(a, b, 16'd32768, 16'd32768, 1'b1, 1'b1);
        send_blend(a, b, 16'd16384, 16'd16384, 1'b0, 1'b0);
        send_blend(a, b, 16'd16384, 16'd0, 1'b1, 1'b1);
        send_blend(a, b, 16'hffff, 16'hffff, 1'b1, 1'b0);
        send_blend(a, b, 16'd1, 16'd1, 1'b1, 1'b1);
        send_blend(a, 64'h0, 16'd32768, 16'd32768, 1'b1, 1'b0);
        send_blend(64'h0, 64'h0, 16'd32768, 16'd32768, 1'b1, 1'b1);
        send_blend(64'h0, b, 16'd20000, 16'd32768, 1'b1, 1'b0);
        send_blend({4{16'h8000}}, {4{16'h7fff}}, 16'd32768, 16'd32768, 1'b1, 1'b0);
        send_blend({4{16'h7fff}}, {4{16'h8000}}, 16'd12345, 16'd30000, 1'b1, 1'b1);
        send_blend({4{16'hffff}}, {4{16'h8000}}, 16'd0, 16'd0, 1'b1, 1'b1);
        send_blend(IDENT, {16'h8001, 48'h0}, 16'd32768, 16'd32768, 1'b1, 1'b0);
        send_blend(IDENT, IDENT, 16'd32768, 16'd32768, 1'b0, 1'b1);
        send_blend({16'h8000, 48'h0}, b, 16'd32767, 16'd32767, 1'b1, 1'b0);

        for (int n = 0; n < 2000; n++) begin
            calm = (n >= 800 && n < 1000);
            if (n == 1200) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            send_blend({rand_comp(), rand_comp(), rand_comp(), rand_comp()},
                       {rand_comp(), rand_comp(), rand_comp(), rand_comp()},
                       rand_scale(), rand_scale(), 1'($urandom), 1'($urandom));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(negedge i_clk);

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/plrb_pkg.sv
rtl/plrb_isqrt.sv
rtl/plrb_div.sv
rtl/plrb_norm.sv
rtl/plrb_outq.sv
rtl/pose_layer_rotation_blend_unit.sv
test/plrb_checker.sv
test/tb_pose_layer_rotation_blend_unit.sv
